// File: rtl/citrus_pixel_classifier_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the classifier's checker
// ---------------------------------------------------------------------------
`ifndef CITRUS_PIXEL_CLASSIFIER_ASSERT_SVH
`define CITRUS_PIXEL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define CPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpc assertion failed");

// Next-cycle implication, off while reset is high
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpc assertion failed");

// Next-cycle implication that also holds across reset
`define CPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cpc assertion failed");

`endif

// File: rtl/cpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpc_pkg
// Types and constants of the citrus pixel classifier.
// ---------------------------------------------------------------------------
package cpc_pkg;

   // Pixel and result payloads
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic       is_citrus;
      logic [8:0] hue_deg;
      logic [7:0] saturation;
   } rsp_type;

   // Control/status register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PEAK      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPREAD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_LOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_HIGH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RED       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GREEN     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_OVER_BLUE = 3'd7;

   typedef struct packed {
      logic [7:0] min_peak_level;
      logic [7:0] min_spread;
      logic [7:0] min_saturation;
      logic [8:0] hue_low;
      logic [8:0] hue_high;
      logic [7:0] min_red;
      logic [7:0] min_green;
      logic [7:0] red_over_blue;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_peak_level: 8'd80,
      min_spread:     8'd35,
      min_saturation: 8'd70,
      hue_low:        9'd12,
      hue_high:       9'd62,
      min_red:        8'd90,
      min_green:      8'd45,
      red_over_blue:  8'd35
   };

   // Hue arithmetic
   localparam logic [6:0] HUE_SCALE = 7'd60;
   localparam logic [8:0] HUE_GREEN = 9'd120;
   localparam logic [8:0] HUE_BLUE  = 9'd240;
   localparam logic [8:0] HUE_FULL  = 9'd360;
   localparam logic [7:0] SAT_SCALE = 8'd255;

   // Fixed ratio tests
   localparam logic [6:0] RATIO_BASE   = 7'd100;
   localparam logic [6:0] BLUE_CAP     = 7'd48;
   localparam logic [6:0] GREEN_FLOOR  = 7'd30;
   localparam logic [6:0] GREEN_CEIL   = 7'd105;
   localparam logic [7:0] GREEN_MARGIN = 8'd15;

   // Divider geometry
   localparam int NUM_W = 16;
   localparam int DEN_W = 8;
   localparam int QUO_W = 8;

   // Which channel is the maximum (red wins ties, then green)
   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   // Side information that rides along with the divider stages
   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       grey;
      logic       black;
      logic       pass;
   } side_type;

endpackage

// File: rtl/citrus_pixel_classifier.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// citrus_pixel_classifier
// Per-pixel RGB to hue/saturation conversion with a citrus color test.
// ---------------------------------------------------------------------------
// While no result is held, one pixel per clock is taken and the sustained
// rate is one pixel per cycle; one result per pixel is returned, in order,
// after two front stages (channel max/min, then operands and fixed tests),
// eight stages of the one-bit-per-stage dividers for hue and saturation,
// and the result register. The whole pipeline holds while a result waits
// under rsp_stall, so req_stall follows rsp_valid and rsp_stall. Registers
// take effect on the next pixel; write them only while no pixel is in flight.
module citrus_pixel_classifier
   import cpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;

   logic             advance;
   logic             fr_valid;
   side_type         fr_side;
   logic [NUM_W-1:0] fr_hue_num, fr_sat_num;
   logic [DEN_W-1:0] fr_spread, fr_peak;
   logic [QUO_W-1:0] hue_quo, sat_quo;

   logic     dv_valid_ff [QUO_W];
   side_type dv_side_ff  [QUO_W];

   // Pipeline moves unless a finished result is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_PEAK:      cfg_ff.min_peak_level <= csr_wdata[7:0];
            CSR_MIN_SPREAD:    cfg_ff.min_spread     <= csr_wdata[7:0];
            CSR_MIN_SAT:       cfg_ff.min_saturation <= csr_wdata[7:0];
            CSR_HUE_LOW:       cfg_ff.hue_low        <= csr_wdata;
            CSR_HUE_HIGH:      cfg_ff.hue_high       <= csr_wdata;
            CSR_MIN_RED:       cfg_ff.min_red        <= csr_wdata[7:0];
            CSR_MIN_GREEN:     cfg_ff.min_green      <= csr_wdata[7:0];
            CSR_RED_OVER_BLUE: cfg_ff.red_over_blue  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   cpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .hue_num   (fr_hue_num),
      .sat_num   (fr_sat_num),
      .spread    (fr_spread),
      .peak      (fr_peak)
   );

   // Hue: 60*|diff| / spread
   cpc_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_hue_div (
      .clock   (clock),
      .enable  (advance),
      .num_in  (fr_hue_num),
      .den_in  (fr_spread),
      .quo_out (hue_quo)
   );

   // Saturation: 255*spread / max
   cpc_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_sat_div (
      .clock   (clock),
      .enable  (advance),
      .num_in  (fr_sat_num),
      .den_in  (fr_peak),
      .quo_out (sat_quo)
   );

   // Valid bits and side data alongside the divider stages
   for (genvar k = 0; k < QUO_W; k++) begin : g_side
      logic     valid_prev;
      side_type side_prev;

      if (k == 0) begin : g_first
         assign valid_prev = fr_valid;
         assign side_prev  = fr_side;
      end else begin : g_next
         assign valid_prev = dv_valid_ff[k-1];
         assign side_prev  = dv_side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_side_ff[k] <= side_prev;
         end
      end
   end

   cpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (dv_valid_ff[QUO_W-1]),
      .in_side   (dv_side_ff[QUO_W-1]),
      .hue_quo   (hue_quo),
      .sat_quo   (sat_quo),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// File: rtl/cpc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpc_front
// Two register stages: channel max/min, then spread, divider operands and
// the threshold tests that do not need hue or saturation.
// ---------------------------------------------------------------------------
module cpc_front
   import cpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  req_type          in_data,
   input  cfg_type          cfg,
   output logic             out_valid,
   output side_type         out_side,
   output logic [NUM_W-1:0] hue_num,
   output logic [NUM_W-1:0] sat_num,
   output logic [DEN_W-1:0] spread,
   output logic [DEN_W-1:0] peak
);

   // Stage A registers
   logic       a_valid_ff;
   req_type    a_pix_ff;
   logic [7:0] a_max_ff, a_max_in;
   logic [7:0] a_min_ff, a_min_in;
   sector_type a_sector_ff, a_sector_in;

   // Stage B registers
   logic             b_valid_ff;
   side_type         b_side_ff, b_side_in;
   logic [NUM_W-1:0] b_hue_num_ff, b_hue_num_in;
   logic [NUM_W-1:0] b_sat_num_ff, b_sat_num_in;
   logic [DEN_W-1:0] b_spread_ff, b_spread_in;
   logic [DEN_W-1:0] b_peak_ff;

   logic        red_top, grn_top;
   logic [8:0]  diff;
   logic [7:0]  mag;
   logic [14:0] blue_x100, peak_x48, grn_x100, red_x30, red_x105;
   logic [8:0]  blue_plus_margin, blue_plus_15;

   // Stage A: maximum, minimum and sector
   always_comb begin
      red_top = (in_data.red >= in_data.green) && (in_data.red >= in_data.blue);
      grn_top = in_data.green >= in_data.blue;
      if (red_top) begin
         a_sector_in = SEC_RED;
         a_max_in    = in_data.red;
      end else if (grn_top) begin
         a_sector_in = SEC_GREEN;
         a_max_in    = in_data.green;
      end else begin
         a_sector_in = SEC_BLUE;
         a_max_in    = in_data.blue;
      end
      if ((in_data.red <= in_data.green) && (in_data.red <= in_data.blue)) begin
         a_min_in = in_data.red;
      end else if (in_data.green <= in_data.blue) begin
         a_min_in = in_data.green;
      end else begin
         a_min_in = in_data.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_pix_ff    <= in_data;
         a_max_ff    <= a_max_in;
         a_min_ff    <= a_min_in;
         a_sector_ff <= a_sector_in;
      end
   end

   // Stage B: spread, signed hue difference, operands and fixed tests
   always_comb begin
      b_spread_in = a_max_ff - a_min_ff;
      case (a_sector_ff)
         SEC_RED:   diff = {1'b0, a_pix_ff.green} - {1'b0, a_pix_ff.blue};
         SEC_GREEN: diff = {1'b0, a_pix_ff.blue} - {1'b0, a_pix_ff.red};
         default:   diff = {1'b0, a_pix_ff.red} - {1'b0, a_pix_ff.green};
      endcase
      mag = diff[8] ? 8'(-diff) : diff[7:0];

      b_hue_num_in = NUM_W'(14'(mag) * 14'(HUE_SCALE));
      b_sat_num_in = 16'(b_spread_in) * 16'(SAT_SCALE);

      blue_x100 = 15'(a_pix_ff.blue) * 15'(RATIO_BASE);
      peak_x48  = 15'(a_max_ff) * 15'(BLUE_CAP);
      grn_x100  = 15'(a_pix_ff.green) * 15'(RATIO_BASE);
      red_x30   = 15'(a_pix_ff.red) * 15'(GREEN_FLOOR);
      red_x105  = 15'(a_pix_ff.red) * 15'(GREEN_CEIL);

      blue_plus_margin = {1'b0, a_pix_ff.blue} + {1'b0, cfg.red_over_blue};
      blue_plus_15     = {1'b0, a_pix_ff.blue} + {1'b0, GREEN_MARGIN};

      b_side_in.sector = a_sector_ff;
      b_side_in.neg    = diff[8];
      b_side_in.grey   = (b_spread_in == 8'd0);
      b_side_in.black  = (a_max_ff == 8'd0);
      b_side_in.pass   = (a_max_ff >= cfg.min_peak_level)
                      && (b_spread_in >= cfg.min_spread)
                      && (a_pix_ff.red >= cfg.min_red)
                      && (a_pix_ff.green >= cfg.min_green)
                      && ({1'b0, a_pix_ff.red} >= blue_plus_margin)
                      && ({1'b0, a_pix_ff.green} >= blue_plus_15)
                      && (blue_x100 <= peak_x48)
                      && (grn_x100 >= red_x30)
                      && (grn_x100 <= red_x105);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_side_ff    <= b_side_in;
         b_hue_num_ff <= b_hue_num_in;
         b_sat_num_ff <= b_sat_num_in;
         b_spread_ff  <= b_spread_in;
         b_peak_ff    <= a_max_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_side  = b_side_ff;
   assign hue_num   = b_hue_num_ff;
   assign sat_num   = b_sat_num_ff;
   assign spread    = b_spread_ff;
   assign peak      = b_peak_ff;

endmodule

// File: rtl/cpc_div_pipe.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpc_div_pipe
// Unsigned restoring divider, one quotient bit per register stage. The
// numerator must be below den * 2**QUO_W; the remainder is dropped.
// ---------------------------------------------------------------------------
module cpc_div_pipe #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8,
   parameter int QUO_W = 8
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [QUO_W-1:0] quo_out
);

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int Bit = QUO_W - 1 - k;

      logic [NUM_W-1:0] rem_prev, trial, rem_in;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev, quo_in;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // Trial subtract of the shifted divisor
      assign trial  = NUM_W'(den_prev) << Bit;
      assign take   = rem_prev >= trial;
      assign rem_in = take ? (rem_prev - trial) : rem_prev;
      assign quo_in = quo_prev | (QUO_W'(take) << Bit);

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];

endmodule

// File: rtl/cpc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpc_back
// Builds hue from sector and quotient, applies hue and saturation tests and
// holds the result register.
// ---------------------------------------------------------------------------
module cpc_back
   import cpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  side_type         in_side,
   input  logic [QUO_W-1:0] hue_quo,
   input  logic [QUO_W-1:0] sat_quo,
   input  cfg_type          cfg,
   output logic             out_valid,
   output rsp_type          out_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic [8:0] hq;
   logic [8:0] hue;
   logic [7:0] sat;

   // Hue from sector offset and signed quotient
   always_comb begin
      hq = 9'(hue_quo);
      case (in_side.sector)
         SEC_RED:   hue = (in_side.neg && (hq != 9'd0)) ? (HUE_FULL - hq) : hq;
         SEC_GREEN: hue = in_side.neg ? (HUE_GREEN - hq) : (HUE_GREEN + hq);
         default:   hue = in_side.neg ? (HUE_BLUE - hq) : (HUE_BLUE + hq);
      endcase
      if (in_side.grey) begin
         hue = 9'd0;
      end
      sat = in_side.black ? 8'd0 : sat_quo;

      rsp_in.hue_deg    = hue;
      rsp_in.saturation = sat;
      rsp_in.is_citrus  = in_side.pass
                       && (sat >= cfg.min_saturation)
                       && (hue >= cfg.hue_low)
                       && (hue <= cfg.hue_high);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// File: rtl/cpc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpc_checker
// Port-level checks of the citrus pixel classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "citrus_pixel_classifier_assert.svh"

module cpc_checker
   import cpc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A held result stays put
   `CPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Input side stalls exactly while a result is held
   `CPC_ASSERT_IMPLY(a_stall_link, clock, reset, 1'b1, req_stall == (rsp_valid && rsp_stall))

   // No result comes out of a freshly reset pipeline
   `CPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // Hue stays within one turn
   `CPC_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_valid, rsp_data.hue_deg <= 9'd359)

   // A citrus pixel has a green-over-blue margin, so it cannot be colorless
   `CPC_ASSERT_IMPLY(a_citrus_sat, clock, reset, rsp_valid && rsp_data.is_citrus, rsp_data.saturation != 8'd0)

endmodule

bind citrus_pixel_classifier cpc_checker u_checker (.*);
